/* hdl/mlfo_pkg.sv */
package mlfo_pkg;

  // Microcode step counter
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = 5'd0;
  localparam step_t ST_MORPH = 5'd14;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THR    = 1'd1;

  localparam logic [31:0] PHASE_SCALE_RST = 32'd1466015504;
  localparam logic [15:0] GATE_THR_RST    = 16'd16384;

  // 1.0 in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Multiplier operand A select
  typedef enum logic [2:0] {
    OPA_NONE  = 3'd0,
    OPA_UN    = 3'd1,
    OPA_U2    = 3'd2,
    OPA_RATE  = 3'd3,
    OPA_DIFF  = 3'd4,
    OPA_DEPTH = 3'd5
  } opa_t;

  // Multiplier operand B select
  typedef enum logic [2:0] {
    OPB_NONE  = 3'd0,
    OPB_UN    = 3'd1,
    OPB_COEF  = 3'd2,
    OPB_T     = 3'd3,
    OPB_SCALE = 3'd4,
    OPB_TM    = 3'd5,
    OPB_WAVE  = 3'd6
  } opb_t;

  // Writeback operation on the registered product
  typedef enum logic [3:0] {
    WB_NONE  = 4'd0,
    WB_SETUP = 4'd1,
    WB_U2    = 4'd2,
    WB_POLY  = 4'd3,
    WB_SINE  = 4'd4,
    WB_AB    = 4'd5,
    WB_INC   = 4'd6,
    WB_MORPH = 4'd7,
    WB_OUT   = 4'd8
  } wb_t;

  // Quarter-sine polynomial coefficients
  typedef enum logic [2:0] {
    COEF_C1 = 3'd0,
    COEF_C3 = 3'd1,
    COEF_C5 = 3'd2,
    COEF_C7 = 3'd3,
    COEF_C9 = 3'd4
  } coef_t;

  // Step sequencing
  typedef enum logic [2:0] {
    JMP_NEXT      = 3'd0,
    JMP_WAIT_IN   = 3'd1,
    JMP_SKIP_SINE = 3'd2,
    JMP_WAIT_OUT  = 3'd3,
    JMP_GOTO      = 3'd4
  } jmp_t;

  // Morph segment: pair of neighbouring shapes
  typedef enum logic [1:0] {
    SEG_SINE_TRI = 2'd0,
    SEG_TRI_SAW  = 2'd1,
    SEG_SAW_SQ   = 2'd2
  } seg_t;

  typedef struct packed {
    opa_t  opa;
    opb_t  opb;
    wb_t   wb;
    coef_t coef;
    jmp_t  jmp;
    logic  ph_wr;
    step_t tgt;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    uword_t uw;
    logic   go;
    logic   accept;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic seg_nz;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [1:0]         lane;
    logic signed [15:0] gate_level;
    logic [16:0]        rate;
    logic [16:0]        shape;
    logic [16:0]        depth;
  } in_item_t;

  function automatic logic [30:0] coef_val(coef_t c);
    logic [30:0] v;
    case (c)
      COEF_C1: v = 31'd1686629713;
      COEF_C3: v = 31'd693598668;
      COEF_C5: v = 31'd85569306;
      COEF_C7: v = 31'd5026995;
      COEF_C9: v = 31'd172272;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic uword_t mk_uw(opa_t a, opb_t b, wb_t w, coef_t c, jmp_t j,
                                   logic p, step_t t);
    uword_t r;
    r.opa   = a;
    r.opb   = b;
    r.wb    = w;
    r.coef  = c;
    r.jmp   = j;
    r.ph_wr = p;
    r.tgt   = t;
    return r;
  endfunction

  // Control program: one word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      5'd0:  w = mk_uw(OPA_NONE,  OPB_NONE,  WB_NONE,  COEF_C1, JMP_WAIT_IN,   1'b0, ST_IDLE);
      5'd1:  w = mk_uw(OPA_NONE,  OPB_NONE,  WB_SETUP, COEF_C1, JMP_SKIP_SINE, 1'b0, ST_MORPH);
      5'd2:  w = mk_uw(OPA_UN,    OPB_UN,    WB_NONE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd3:  w = mk_uw(OPA_NONE,  OPB_NONE,  WB_U2,    COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd4:  w = mk_uw(OPA_U2,    OPB_COEF,  WB_NONE,  COEF_C9, JMP_NEXT,      1'b0, ST_IDLE);
      5'd5:  w = mk_uw(OPA_NONE,  OPB_NONE,  WB_POLY,  COEF_C7, JMP_NEXT,      1'b0, ST_IDLE);
      5'd6:  w = mk_uw(OPA_U2,    OPB_T,     WB_NONE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd7:  w = mk_uw(OPA_NONE,  OPB_NONE,  WB_POLY,  COEF_C5, JMP_NEXT,      1'b0, ST_IDLE);
      5'd8:  w = mk_uw(OPA_U2,    OPB_T,     WB_NONE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd9:  w = mk_uw(OPA_NONE,  OPB_NONE,  WB_POLY,  COEF_C3, JMP_NEXT,      1'b0, ST_IDLE);
      5'd10: w = mk_uw(OPA_U2,    OPB_T,     WB_NONE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd11: w = mk_uw(OPA_NONE,  OPB_NONE,  WB_POLY,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd12: w = mk_uw(OPA_UN,    OPB_T,     WB_NONE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd13: w = mk_uw(OPA_NONE,  OPB_NONE,  WB_SINE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd14: w = mk_uw(OPA_RATE,  OPB_SCALE, WB_AB,    COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd15: w = mk_uw(OPA_DIFF,  OPB_TM,    WB_INC,   COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd16: w = mk_uw(OPA_NONE,  OPB_NONE,  WB_MORPH, COEF_C1, JMP_NEXT,      1'b1, ST_IDLE);
      5'd17: w = mk_uw(OPA_DEPTH, OPB_WAVE,  WB_NONE,  COEF_C1, JMP_NEXT,      1'b0, ST_IDLE);
      5'd18: w = mk_uw(OPA_NONE,  OPB_NONE,  WB_OUT,   COEF_C1, JMP_WAIT_OUT,  1'b0, ST_IDLE);
      default: w = mk_uw(OPA_NONE, OPB_NONE, WB_NONE,  COEF_C1, JMP_GOTO,      1'b0, ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

/* hdl/mlfo_seq.sv */
module mlfo_seq import mlfo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output ctl_t ctl
);

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   go;

  assign uw = ucode(step_r);

  // Next step and step-complete qualifier
  always_comb begin
    step_nxt = step_r;
    go       = 1'b1;
    case (uw.jmp)
      JMP_NEXT: begin
        step_nxt = step_t'(step_r + 1'b1);
      end
      JMP_WAIT_IN: begin
        go = in_valid;
        if (in_valid) begin
          step_nxt = step_t'(step_r + 1'b1);
        end
      end
      JMP_SKIP_SINE: begin
        step_nxt = sts.seg_nz ? uw.tgt : step_t'(step_r + 1'b1);
      end
      JMP_WAIT_OUT: begin
        go = sts.out_free;
        if (sts.out_free) begin
          step_nxt = uw.tgt;
        end
      end
      JMP_GOTO: begin
        step_nxt = uw.tgt;
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // No request is taken while reset is held
  assign in_ready   = rst_n && (uw.jmp == JMP_WAIT_IN);
  assign ctl.uw     = uw;
  assign ctl.go     = go;
  assign ctl.accept = in_valid & in_ready;

endmodule

/* hdl/mlfo_dp.sv */
module mlfo_dp import mlfo_pkg::*; #(
  parameter int LANE_COUNT = 4,
  parameter int TBL_BITS   = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  input  in_item_t           item,
  input  logic [31:0]        phase_scale,
  input  logic signed [15:0] gate_thr,
  input  logic               out_ready,
  output sts_t               sts,
  output logic               out_valid,
  output logic [1:0]         out_lane,
  output logic signed [15:0] out_wave
);

  localparam int SLOT_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int UN_W   = TBL_BITS - 1;
  localparam int U2_SH  = 34 - 2 * TBL_BITS;
  localparam int V_LSB  = TBL_BITS - 2;
  localparam logic [TBL_BITS-1:0] QUARTER_K = TBL_BITS'(1) << (TBL_BITS - 2);
  localparam logic [5:0] LC1 = 6'(LANE_COUNT);
  localparam logic [5:0] LC2 = 6'(2 * LANE_COUNT);
  localparam logic [5:0] LC3 = 6'(3 * LANE_COUNT);

  // Per-lane state
  logic [31:0]           lane_phase_r [LANE_COUNT];
  logic [LANE_COUNT-1:0] gate_was_high_r;

  // Item registers
  logic [31:0]       phase_r;
  logic [SLOT_W-1:0] slot_r;
  logic [1:0]        lane_r;
  logic [16:0]       rate_r;
  logic [16:0]       depth_r;
  seg_t              seg_r;
  logic [16:0]       tm_r;

  // Working registers
  logic [UN_W-1:0]    un_r;
  logic               neg_r;
  logic [30:0]        u2_r;
  logic [30:0]        t_r;
  logic signed [17:0] sine_r;
  logic signed [17:0] a_r;
  logic signed [19:0] diff_r;
  logic [31:0]        inc_r;
  logic signed [17:0] wave_r;
  logic signed [65:0] prod_r;

  // Output register
  logic               out_valid_r;
  logic [1:0]         out_lane_r;
  logic signed [15:0] out_wave_r;

  // Slot = lane modulo lane count (lane is at most 3)
  logic [5:0]        lane_x;
  logic [5:0]        slot_x;
  logic [SLOT_W-1:0] slot_in;

  always_comb begin
    lane_x = 6'(item.lane);
    if (lane_x < LC1) begin
      slot_x = lane_x;
    end else if (lane_x < LC2) begin
      slot_x = lane_x - LC1;
    end else if (lane_x < LC3) begin
      slot_x = lane_x - LC2;
    end else begin
      slot_x = lane_x - LC3;
    end
    slot_in = SLOT_W'(slot_x);
  end

  // Gate edge and morph position at request time
  logic        gate_hi;
  logic        rise;
  logic [16:0] sh_c;
  logic [17:0] s3_c;
  seg_t        seg_c;
  logic [16:0] tm_c;

  assign gate_hi = (item.gate_level >= gate_thr);
  assign rise    = gate_hi && !gate_was_high_r[slot_in];

  always_comb begin
    sh_c = (item.shape > ONE_Q16) ? ONE_Q16 : item.shape;
    s3_c = 18'(sh_c) + (18'(sh_c) << 1);
    if (s3_c[17:16] == 2'b11) begin
      seg_c = SEG_SAW_SQ;
      tm_c  = ONE_Q16;
    end else begin
      seg_c = seg_t'(s3_c[17:16]);
      tm_c  = {1'b0, s3_c[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      phase_r <= rise ? 32'd0 : lane_phase_r[slot_in];
      slot_r  <= slot_in;
      lane_r  <= item.lane;
      rate_r  <= item.rate;
      depth_r <= item.depth;
      seg_r   <= seg_c;
      tm_r    <= tm_c;
    end
  end

  // Lane phase and gate history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        lane_phase_r[i] <= '0;
      end
      gate_was_high_r <= '0;
    end else begin
      if (ctl.accept) begin
        gate_was_high_r[slot_in] <= gate_hi;
      end
      if (ctl.uw.ph_wr && ctl.go) begin
        lane_phase_r[slot_r] <= phase_r + inc_r;
      end
    end
  end

  // Quarter-wave argument: -cos(x) = sin(x - pi/2)
  logic [TBL_BITS-1:0] k_c;
  logic [TBL_BITS-1:0] ang_c;
  logic [1:0]          quad_c;
  logic [TBL_BITS-3:0] r_c;
  logic [UN_W-1:0]     un_c;

  always_comb begin
    k_c    = phase_r[31 -: TBL_BITS];
    ang_c  = k_c - QUARTER_K;
    quad_c = ang_c[TBL_BITS-1 -: 2];
    r_c    = ang_c[TBL_BITS-3:0];
    un_c   = quad_c[0] ? (UN_W'(QUARTER_K) - UN_W'(r_c)) : UN_W'(r_c);
  end

  // Sine from polynomial result, Q1.16 rounded and limited
  logic [31:0]        v_c;
  logic [31:0]        vr_c;
  logic [17:0]        q_c;
  logic [17:0]        qc_c;
  logic signed [17:0] sine_c;

  always_comb begin
    v_c    = prod_r[V_LSB +: 32];
    vr_c   = v_c + 32'd8192;
    q_c    = vr_c[31:14];
    qc_c   = (q_c > 18'(ONE_Q16)) ? 18'(ONE_Q16) : q_c;
    sine_c = neg_r ? -$signed(qc_c) : $signed(qc_c);
  end

  // Basic shapes and morph endpoints
  logic signed [19:0] ph14_c;
  logic signed [19:0] tri_c;
  logic signed [19:0] saw_c;
  logic signed [19:0] sq_c;
  logic signed [19:0] sin_x;
  logic signed [19:0] a_sel;
  logic signed [19:0] b_sel;

  always_comb begin
    ph14_c = $signed({2'b00, phase_r[31:14]});
    tri_c  = phase_r[31] ? (20'sd196608 - ph14_c) : (ph14_c - 20'sd65536);
    saw_c  = $signed({3'b000, phase_r[31:15]}) - 20'sd65536;
    sq_c   = phase_r[31] ? -20'sd65536 : 20'sd65536;
    sin_x  = 20'(sine_r);
    case (seg_r)
      SEG_SINE_TRI: begin
        a_sel = sin_x;
        b_sel = tri_c;
      end
      SEG_TRI_SAW: begin
        a_sel = tri_c;
        b_sel = saw_c;
      end
      default: begin
        a_sel = saw_c;
        b_sel = sq_c;
      end
    endcase
  end

  // Rounded crossfade and rounded, saturated output
  logic signed [65:0] rnd16_c;
  logic signed [65:0] rnd17_c;
  logic [19:0]        wave_x;
  logic signed [17:0] wave_c;
  logic signed [23:0] y_c;
  logic signed [15:0] sat_c;

  always_comb begin
    rnd16_c = prod_r + 66'sd32768;
    wave_x  = 20'(a_r) + rnd16_c[35:16];
    wave_c  = $signed(wave_x[17:0]);
    rnd17_c = prod_r + 66'sd65536;
    y_c     = rnd17_c[40:17];
    if (y_c > 24'sd32767) begin
      sat_c = 16'sh7FFF;
    end else if (y_c < -24'sd32768) begin
      sat_c = 16'sh8000;
    end else begin
      sat_c = y_c[15:0];
    end
  end

  // Shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  always_comb begin
    case (ctl.uw.opa)
      OPA_UN:    mul_a = 33'(un_r);
      OPA_U2:    mul_a = 33'(u2_r);
      OPA_RATE:  mul_a = 33'(rate_r);
      OPA_DIFF:  mul_a = 33'(diff_r);
      OPA_DEPTH: mul_a = 33'(depth_r);
      default:   mul_a = '0;
    endcase
    case (ctl.uw.opb)
      OPB_UN:    mul_b = 33'(un_r);
      OPB_COEF:  mul_b = 33'(coef_val(ctl.uw.coef));
      OPB_T:     mul_b = 33'(t_r);
      OPB_SCALE: mul_b = 33'(phase_scale);
      OPB_TM:    mul_b = 33'(tm_r);
      OPB_WAVE:  mul_b = 33'(wave_r);
      default:   mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.uw.opa != OPA_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Writeback of the registered product
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.uw.wb)
        WB_SETUP: begin
          un_r  <= un_c;
          neg_r <= quad_c[1];
        end
        WB_U2:    u2_r   <= prod_r[30:0] << U2_SH;
        WB_POLY:  t_r    <= coef_val(ctl.uw.coef) - prod_r[60:30];
        WB_SINE:  sine_r <= sine_c;
        WB_AB: begin
          a_r    <= a_sel[17:0];
          diff_r <= b_sel - a_sel;
        end
        WB_INC:   inc_r  <= prod_r[55:24];
        WB_MORPH: wave_r <= wave_c;
        default: ;
      endcase
    end
  end

  // Output register
  logic out_load;
  assign out_load = (ctl.uw.wb == WB_OUT) && ctl.go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lane_r <= lane_r;
      out_wave_r <= sat_c;
    end
  end

  assign sts.seg_nz   = (seg_r != SEG_SINE_TRI);
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_lane     = out_lane_r;
  assign out_wave     = out_wave_r;

endmodule

/* hdl/morphing_lfo_with_reset.sv */
// The sine polynomial runs on the shared 33x33 multiplier only when the morph lies in the
//   sine-triangle third; for the other thirds the program skips it.
// One request at a time: a new request is taken only once the microcode program is back at
//   idle. All steps share the single multiplier. A held result stalls only the last step.
// Reset: synchronous active-low rst_n clears the step counter, lane phases, gate history and
//   output valid, and loads phase_scale and gate_threshold defaults.
module morphing_lfo_with_reset import mlfo_pkg::*; #(
  parameter int LANE_COUNT      = 4,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,   // gate_level[15:0], rate[32:16], shape[49:33],
                                           // depth[66:50], zero pad[71:67]
  input  logic [1:0]           in_tuser,   // lane[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // wave[15:0]
  output logic [1:0]           out_tuser,  // lane_out[1:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata
);

  logic [31:0]        scale_r;
  logic signed [15:0] thr_r;
  in_item_t           item;
  ctl_t               ctl;
  sts_t               sts;
  logic [15:0]        wave_w;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= PHASE_SCALE_RST;
      thr_r   <= GATE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PHASE_SCALE: scale_r <= cfg_wdata;
        REG_GATE_THR:    thr_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Request unpacking
  assign item.lane       = in_tuser;
  assign item.gate_level = in_tdata[15:0];
  assign item.rate       = in_tdata[32:16];
  assign item.shape      = in_tdata[49:33];
  assign item.depth      = in_tdata[66:50];

  mlfo_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .sts      (sts),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  mlfo_dp #(
    .LANE_COUNT (LANE_COUNT),
    .TBL_BITS   (SINE_TABLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .item        (item),
    .phase_scale (scale_r),
    .gate_thr    (thr_r),
    .out_ready   (out_tready),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_lane    (out_tuser),
    .out_wave    (wave_w)
  );

  assign out_tdata = wave_w;

endmodule

/* hdl/mlfo_chk.sv */
module mlfo_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("held result changed");

  // One request at a time: the sequencer leaves idle after a request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request taken while previous one in progress");

  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_fire) && !$past(in_fire, 2))
    else $error("result too soon after request");

endmodule

bind morphing_lfo_with_reset mlfo_chk u_mlfo_chk (.*);
